FILE: rtl/scrypt_pkg.sv
package scrypt_pkg;
    localparam int MAX_LOG2_N = 10;
    localparam int SPAD_ENTRIES = 1 << MAX_LOG2_N;
    localparam int SPAD_DEPTH = SPAD_ENTRIES * 32;
    localparam int SPAD_AW = MAX_LOG2_N + 5;
    localparam int NCNT_W = MAX_LOG2_N + 1;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic load_word;
        logic spad_write;
        logic xor_spad;
        logic mix_start;
        logic shift_out;
    } scr_cmd_t;

    typedef struct packed {
        logic mix_busy;
        logic mix_done;
    } scr_status_t;

    function automatic word_t rotl(input word_t v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction
endpackage

FILE: rtl/scrypt_ram.sv
module scrypt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/scrypt_datapath.sv
module scrypt_datapath (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  scrypt_pkg::scr_cmd_t    cmd,
    input  scrypt_pkg::word_t       in_word,
    input  scrypt_pkg::word_t       spad_word,
    output scrypt_pkg::scr_status_t status,
    output scrypt_pkg::word_t       head_word,
    output scrypt_pkg::word_t       sel_word
);
    import scrypt_pkg::*;

    // block kept as a 32-word rotating shift line; word 0 at head
    word_t blk_reg [32];
    word_t x_reg [16];
    word_t x_next [16];
    word_t t [16];
    logic [2:0] rnd_reg;
    logic       half_reg;
    logic [1:0] ph_reg;
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RUN  = 2'd1;
    localparam logic [1:0] PH_FF   = 2'd2;

    assign head_word = blk_reg[0];
    assign sel_word = blk_reg[16];
    assign status.mix_busy = ph_reg != PH_IDLE;
    assign status.mix_done = (ph_reg == PH_FF) && half_reg;

    // one double-round split in column or row half-step per cycle
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            t[i] = x_reg[i];
        end
        if (!rnd_reg[0]) begin
            t[4]  = t[4]  ^ rotl(t[0]  + t[12], 7);
            t[9]  = t[9]  ^ rotl(t[5]  + t[1],  7);
            t[14] = t[14] ^ rotl(t[10] + t[6],  7);
            t[3]  = t[3]  ^ rotl(t[15] + t[11], 7);
            t[8]  = t[8]  ^ rotl(t[4]  + t[0],  9);
            t[13] = t[13] ^ rotl(t[9]  + t[5],  9);
            t[2]  = t[2]  ^ rotl(t[14] + t[10], 9);
            t[7]  = t[7]  ^ rotl(t[3]  + t[15], 9);
            t[12] = t[12] ^ rotl(t[8]  + t[4],  13);
            t[1]  = t[1]  ^ rotl(t[13] + t[9],  13);
            t[6]  = t[6]  ^ rotl(t[2]  + t[14], 13);
            t[11] = t[11] ^ rotl(t[7]  + t[3],  13);
            t[0]  = t[0]  ^ rotl(t[12] + t[8],  18);
            t[5]  = t[5]  ^ rotl(t[1]  + t[13], 18);
            t[10] = t[10] ^ rotl(t[6]  + t[2],  18);
            t[15] = t[15] ^ rotl(t[11] + t[7],  18);
        end else begin
            t[1]  = t[1]  ^ rotl(t[0]  + t[3],  7);
            t[6]  = t[6]  ^ rotl(t[5]  + t[4],  7);
            t[11] = t[11] ^ rotl(t[10] + t[9],  7);
            t[12] = t[12] ^ rotl(t[15] + t[14], 7);
            t[2]  = t[2]  ^ rotl(t[1]  + t[0],  9);
            t[7]  = t[7]  ^ rotl(t[6]  + t[5],  9);
            t[8]  = t[8]  ^ rotl(t[11] + t[10], 9);
            t[13] = t[13] ^ rotl(t[12] + t[15], 9);
            t[3]  = t[3]  ^ rotl(t[2]  + t[1],  13);
            t[4]  = t[4]  ^ rotl(t[7]  + t[6],  13);
            t[9]  = t[9]  ^ rotl(t[8]  + t[11], 13);
            t[14] = t[14] ^ rotl(t[13] + t[12], 13);
            t[0]  = t[0]  ^ rotl(t[3]  + t[2],  18);
            t[5]  = t[5]  ^ rotl(t[4]  + t[7],  18);
            t[10] = t[10] ^ rotl(t[9]  + t[8],  18);
            t[15] = t[15] ^ rotl(t[14] + t[13], 18);
        end
        for (int i = 0; i < 16; i++) begin
            x_next[i] = t[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= PH_IDLE;
            rnd_reg <= '0;
            half_reg <= 1'b0;
        end else begin
            case (ph_reg)
                PH_IDLE: begin
                    if (cmd.mix_start) begin
                        for (int i = 0; i < 16; i++) begin
                            x_reg[i] <= blk_reg[i] ^ blk_reg[i+16];
                            blk_reg[i] <= blk_reg[i] ^ blk_reg[i+16];
                        end
                        rnd_reg <= '0;
                        half_reg <= 1'b0;
                        ph_reg <= PH_RUN;
                    end
                end
                PH_RUN: begin
                    for (int i = 0; i < 16; i++) begin
                        x_reg[i] <= x_next[i];
                    end
                    rnd_reg <= rnd_reg + 3'd1;
                    if (rnd_reg == 3'd7) begin
                        ph_reg <= PH_FF;
                    end
                end
                PH_FF: begin
                    // feed-forward, then swap halves so the next half is at the front
                    for (int i = 0; i < 16; i++) begin
                        blk_reg[i] <= blk_reg[i+16];
                        blk_reg[i+16] <= blk_reg[i] + x_reg[i];
                    end
                    if (!half_reg) begin
                        for (int i = 0; i < 16; i++) begin
                            x_reg[i] <= blk_reg[i+16] ^ (blk_reg[i] + x_reg[i]);
                            blk_reg[i] <= blk_reg[i+16] ^ (blk_reg[i] + x_reg[i]);
                        end
                        half_reg <= 1'b1;
                        rnd_reg <= '0;
                        ph_reg <= PH_RUN;
                    end else begin
                        ph_reg <= PH_IDLE;
                    end
                end
                default: ph_reg <= PH_IDLE;
            endcase
            if (ph_reg == PH_IDLE && !cmd.mix_start) begin
                if (cmd.load_word || cmd.shift_out || cmd.spad_write || cmd.xor_spad) begin
                    for (int i = 0; i < 31; i++) begin
                        blk_reg[i] <= blk_reg[i+1];
                    end
                    blk_reg[31] <= cmd.load_word ? in_word :
                                   cmd.xor_spad ? (blk_reg[0] ^ spad_word) : blk_reg[0];
                end
            end
        end
    end
endmodule

FILE: rtl/scrypt_ctrl.sv
module scrypt_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         out_last,
    input  logic                         cfg_valid,
    input  logic [3:0]                   cfg_data,
    input  scrypt_pkg::scr_status_t      status,
    input  scrypt_pkg::word_t            sel_word,
    output scrypt_pkg::scr_cmd_t         cmd,
    output logic [scrypt_pkg::SPAD_AW-1:0] waddr,
    output logic [scrypt_pkg::SPAD_AW-1:0] raddr
);
    import scrypt_pkg::*;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_STORE = 3'd1;
    localparam logic [2:0] S_MIX   = 3'd2;
    localparam logic [2:0] S_PREP  = 3'd3;
    localparam logic [2:0] S_XOR   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] st_reg;
    logic [3:0] log2n_reg;
    logic [4:0] cnt_reg;
    logic [NCNT_W-1:0] it_reg;
    logic loop2_reg;
    logic [MAX_LOG2_N-1:0] sel_reg;
    logic [MAX_LOG2_N-1:0] sel_now;
    logic [MAX_LOG2_N-1:0] nmask;
    logic [NCNT_W-1:0] nlast;
    logic [3:0] nl;

    assign nl = (log2n_reg > 4'(MAX_LOG2_N)) ? 4'(MAX_LOG2_N) : log2n_reg;
    assign nmask = MAX_LOG2_N'((NCNT_W'(1) << nl) - NCNT_W'(1));
    assign nlast = NCNT_W'(nmask);
    assign sel_now = sel_word[MAX_LOG2_N-1:0] & nmask;

    assign in_ready = st_reg == S_LOAD;
    assign out_valid = st_reg == S_OUT;
    assign out_last = cnt_reg == 5'd31;
    assign waddr = {it_reg[MAX_LOG2_N-1:0], cnt_reg};
    // read one ahead: word 0 of the selected entry in prep, cnt+1 during xor pass
    assign raddr = (st_reg == S_XOR) ? {sel_reg, cnt_reg + 5'd1} : {sel_now, 5'd0};

    always_comb begin
        cmd = '0;
        cmd.load_word = (st_reg == S_LOAD) && in_valid;
        cmd.spad_write = st_reg == S_STORE;
        cmd.xor_spad = st_reg == S_XOR;
        cmd.shift_out = (st_reg == S_OUT) && out_ready;
        cmd.mix_start = (st_reg == S_MIX) && !status.mix_busy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_LOAD;
            log2n_reg <= 4'd10;
            cnt_reg <= '0;
            it_reg <= '0;
            loop2_reg <= 1'b0;
            sel_reg <= '0;
        end else begin
            if (cfg_valid) begin
                log2n_reg <= cfg_data;
            end
            case (st_reg)
                S_LOAD: begin
                    if (in_valid) begin
                        cnt_reg <= cnt_reg + 5'd1;
                        if (cnt_reg == 5'd31) begin
                            st_reg <= S_STORE;
                            it_reg <= '0;
                            loop2_reg <= 1'b0;
                        end
                    end
                end
                S_STORE: begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31) begin
                        st_reg <= S_MIX;
                    end
                end
                S_MIX: begin
                    if (status.mix_done) begin
                        it_reg <= it_reg + NCNT_W'(1);
                        if (it_reg == nlast) begin
                            it_reg <= '0;
                            if (loop2_reg) begin
                                st_reg <= S_OUT;
                            end else begin
                                loop2_reg <= 1'b1;
                                st_reg <= S_PREP;
                            end
                        end else begin
                            st_reg <= loop2_reg ? S_PREP : S_STORE;
                        end
                    end
                end
                S_PREP: begin
                    sel_reg <= sel_now;
                    st_reg <= S_XOR;
                end
                S_XOR: begin
                    if (cnt_reg == 5'd31) begin
                        st_reg <= S_MIX;
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                end
                S_OUT: begin
                    if (out_ready) begin
                        cnt_reg <= cnt_reg + 5'd1;
                        if (cnt_reg == 5'd31) begin
                            st_reg <= S_LOAD;
                        end
                    end
                end
                default: st_reg <= S_LOAD;
            endcase
        end
    end
endmodule

FILE: rtl/scrypt_romix_salsa20_8.sv
// Loads 32 words, one per beat; then runs ROMix with N = 2^log2_n (capped at 10).
// Each BlockMix has a start step, then two Salsa20/8 cores of 8 half-rounds plus one
// feed-forward step each on one shared round unit; each store pass writes 32 words,
// and each scratchpad XOR pass has one address step, then 32 words.
// After ROMix the result leaves as 32 output beats.
// One block at a time: no new block is taken until its last output beat is sent.
// aresetn is synchronous, active low; it drops a partly loaded block and sets log2_n to 10.
module scrypt_romix_salsa20_8 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // data_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result_word
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);
    import scrypt_pkg::*;

    scr_cmd_t cmd;
    scr_status_t status;
    word_t head_word, sel_word, spad_word;
    logic [SPAD_AW-1:0] waddr, raddr;

    assign cfg_ready = 1'b1;
    assign m_tdata = head_word;

    scrypt_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_last(m_tlast),
        .cfg_valid, .cfg_data,
        .status, .sel_word, .cmd, .waddr, .raddr
    );

    scrypt_ram #(.WIDTH(32), .DEPTH(SPAD_DEPTH)) u_spad (
        .aclk, .we(cmd.spad_write), .waddr, .wdata(head_word),
        .raddr, .rdata(spad_word)
    );

    scrypt_datapath u_dp (
        .aclk, .aresetn, .cmd, .in_word(s_tdata), .spad_word,
        .status, .head_word, .sel_word
    );
endmodule
